// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- design/plr_pkg.sv -----
// ----------------------------------------------------------------------------
// plr_pkg
// Constants for the polyline arc-length resampler.
// ----------------------------------------------------------------------------
package plr_pkg;
  localparam int unsigned MAX_EMIT = 64;
  localparam int unsigned CNT_W    = $clog2(MAX_EMIT + 1);
  localparam int unsigned ACC_W    = 40;
  localparam logic [30:0] STEP_RESET = 31'd65536;

  // result kinds
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_INTERP = 2'd1;
  localparam logic [1:0] KIND_FINAL  = 2'd2;

  // register addresses
  localparam logic [1:0] ADDR_STEP = 2'd0;
endpackage

// ----- design/polyline_arclength_resampler.sv -----
// ----------------------------------------------------------------------------
// polyline_arclength_resampler
// Resamples a 3D Q16.16 polyline at a fixed arc-length spacing.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | pos, dir, last_point
//  out     | source    | out_valid/out_stall| out pos/dir, kind, flags
//  cfg     | APB slave | psel/penable       | step_length at address 0
//
//  First point: held in S_FIRST, loaded into the output register when it is free.
//  Other points: squares of the three axis offsets summed, 32 root steps at 2
//  radicand bits, a count of due results, then three bit-serial divides per
//  interpolated point, skipped on a zero-length segment; then any final point.
//  One item at a time; the next item is taken once all results are loaded.
//  Output stall only holds the sequencer at a result load; async low reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyline_arclength_resampler (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] pos_x_i,
  input  logic signed [30:0] pos_y_i,
  input  logic signed [30:0] pos_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic               last_point_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_dir_x_o,
  output logic signed [31:0] out_dir_y_o,
  output logic signed [31:0] out_dir_z_o,
  output logic [1:0]         point_kind_o,
  output logic               truncated_o,
  output logic               last_result_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_SQI   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_CNT   = 4'd6;
  localparam logic [3:0] S_TCALC = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DIVI  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_PUT   = 4'd11;
  localparam logic [3:0] S_FINAL = 4'd12;

  localparam int unsigned CW = plr_pkg::CNT_W;
  localparam int unsigned AW = plr_pkg::ACC_W;

  logic [3:0]         st_q, st_d;
  logic [30:0]        step_q;
  logic               started_q, started_d;
  logic [31:0]        prev_q [3];
  logic [31:0]        prev_d [3];
  logic [AW-1:0]      acc_q, acc_d;
  logic [31:0]        s_q [3];
  logic [31:0]        s_d [3];
  logic [31:0]        diff_q [3];
  logic [31:0]        diff_d [3];
  logic [31:0]        dir_q [3];
  logic               last_q;
  logic [1:0]         ph_q, ph_d;
  logic [63:0]        prod_q, prod_d;
  logic [63:0]        sum_q, sum_d;
  logic [63:0]        rad_q, rad_d;
  logic [32:0]        rem_q, rem_d;
  logic [31:0]        root_q, root_d;
  logic [4:0]         it_q, it_d;
  logic [31:0]        norm_q, norm_d;
  logic [AW-1:0]      tmp_q, tmp_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      k_q, k_d;
  logic               trunc_q, trunc_d;
  logic [31:0]        t_q, t_d;
  logic [1:0]         axis_q, axis_d;
  logic [31:0]        drem_q, drem_d;
  logic [30:0]        dsh_q, dsh_d;
  logic [30:0]        quo_q, quo_d;
  logic [30:0]        off_q [3];
  logic [30:0]        off_d [3];

  // output register
  logic               ovld_q, ovld_d;
  logic [31:0]        opos_q [3];
  logic [31:0]        odir_q [3];
  logic [1:0]         okind_q;
  logic               otrunc_q, olast_q;
  logic               load;
  logic [31:0]        lpos [3];
  logic [31:0]        ldir [3];
  logic [1:0]         lkind;
  logic               llast;

  logic               in_acc, out_free, cfg_wr;
  logic [30:0]        mag [3];
  logic [30:0]        mag_sel;
  logic [31:0]        mul_b;
  logic [1:0]         sel;
  logic [34:0]        sq_rem2;
  logic [33:0]        sq_trial;
  logic               sq_ge;
  logic [AW:0]        acc_sum;
  logic [AW-1:0]      acc_sat;
  logic               due;
  logic [CW-1:0]      limit;
  logic [AW:0]        t_wide;
  logic [32:0]        dv_r2;
  logic               dv_ge;
  logic [31:0]        in_s [3];

  assign in_s[0] = {pos_x_i[30], pos_x_i};
  assign in_s[1] = {pos_y_i[30], pos_y_i};
  assign in_s[2] = {pos_z_i[30], pos_z_i};

  assign in_stall_o = (st_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ovld_q || !out_stall_i;

  // APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == plr_pkg::ADDR_STEP);
  assign prdata = (paddr == plr_pkg::ADDR_STEP) ? {1'b0, step_q} : 32'd0;

  // segment magnitudes per axis
  for (genvar a = 0; a < 3; a++) begin : g_mag
    assign mag[a] = diff_q[a][31] ? 31'(-diff_q[a]) : diff_q[a][30:0];
  end

  // shared multiplier operands
  assign sel = (st_q == S_SQ) ? ph_q : axis_q;
  always_comb begin
    case (sel)
      2'd0:    mag_sel = mag[0];
      2'd1:    mag_sel = mag[1];
      2'd2:    mag_sel = mag[2];
      default: mag_sel = '0;
    endcase
  end
  assign mul_b = (st_q == S_SQ) ? {1'b0, mag_sel} : t_q;

  // square root step: two radicand bits a cycle
  assign sq_rem2  = {rem_q, rad_q[63:62]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_ge    = (sq_rem2 >= {1'b0, sq_trial});

  // accumulate with saturation
  assign acc_sum = {1'b0, acc_q} + {{(AW + 1 - 32){1'b0}}, norm_q};
  assign acc_sat = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];

  // emission test on the scratch accumulator
  assign due   = last_q ? (tmp_q >= {{(AW - 31){1'b0}}, step_q})
                        : (tmp_q >  {{(AW - 31){1'b0}}, step_q});
  assign limit = last_q ? CW'(plr_pkg::MAX_EMIT - 1) : CW'(plr_pkg::MAX_EMIT);
  assign t_wide = {1'b0, acc_q} - {{(AW + 1 - 31){1'b0}}, step_q};

  // divider step: one quotient bit a cycle
  assign dv_r2 = {drem_q, dsh_q[30]};
  assign dv_ge = (dv_r2 >= {1'b0, norm_q});

  // result load values
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lpos[a] = s_q[a];
      ldir[a] = dir_q[a];
    end
    lkind = plr_pkg::KIND_FIRST;
    llast = 1'b1;
    if (st_q == S_PUT) begin
      for (int a = 0; a < 3; a++) begin
        lpos[a] = diff_q[a][31] ? s_q[a] + {1'b0, off_q[a]} : s_q[a] - {1'b0, off_q[a]};
        ldir[a] = diff_q[a];
      end
      lkind = plr_pkg::KIND_INTERP;
      llast = (k_q == cnt_q - CW'(1)) && !last_q;
    end else if (st_q == S_FINAL) begin
      lkind = plr_pkg::KIND_FINAL;
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q; started_d = started_q; acc_d = acc_q;
    ph_d = ph_q; prod_d = prod_q; sum_d = sum_q; rad_d = rad_q; rem_d = rem_q;
    root_d = root_q; it_d = it_q; norm_d = norm_q; tmp_d = tmp_q; cnt_d = cnt_q;
    k_d = k_q; trunc_d = trunc_q; t_d = t_q; axis_d = axis_q; drem_d = drem_q;
    dsh_d = dsh_q; quo_d = quo_q; load = 1'b0;
    for (int a = 0; a < 3; a++) begin
      prev_d[a] = prev_q[a]; s_d[a] = s_q[a]; diff_d[a] = diff_q[a];
      off_d[a] = off_q[a];
    end
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          for (int a = 0; a < 3; a++) begin
            s_d[a]    = in_s[a];
            diff_d[a] = in_s[a] - prev_q[a];
          end
          if (!started_q) begin
            if (!last_point_i) st_d = S_FIRST;
          end else begin
            st_d  = S_SQ;
            ph_d  = 2'd0;
            sum_d = '0;
          end
        end
      end
      S_FIRST: begin
        if (out_free) begin
          load      = 1'b1;
          trunc_d   = 1'b0;
          started_d = 1'b1;
          acc_d     = '0;
          for (int a = 0; a < 3; a++) prev_d[a] = s_q[a];
          st_d = S_IDLE;
        end
      end
      S_SQ: begin
        prod_d = {1'b0, 63'(mag_sel * mul_b)};
        if (ph_q != 2'd0) sum_d = sum_q + prod_q;
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) st_d = S_SQI;
      end
      S_SQI: begin
        rad_d = sum_q; rem_d = '0; root_d = '0; it_d = '0;
        st_d  = S_SQRT;
      end
      S_SQRT: begin
        rem_d  = sq_ge ? 33'(sq_rem2 - {1'b0, sq_trial}) : sq_rem2[32:0];
        root_d = {root_q[30:0], sq_ge};
        rad_d  = {rad_q[61:0], 2'b00};
        it_d   = it_q + 5'd1;
        if (it_q == 5'd31) begin
          norm_d = {root_q[30:0], sq_ge};
          st_d   = S_ACC;
        end
      end
      S_ACC: begin
        acc_d = acc_sat; tmp_d = acc_sat; cnt_d = '0; k_d = '0; trunc_d = 1'b0;
        for (int a = 0; a < 3; a++) prev_d[a] = s_q[a];
        st_d = S_CNT;
      end
      S_CNT: begin
        if (!due || cnt_q >= limit) begin
          trunc_d = due;
          if (cnt_q != '0)  st_d = S_TCALC;
          else if (last_q)  st_d = S_FINAL;
          else              st_d = S_IDLE;
        end else begin
          tmp_d = tmp_q - {{(AW - 31){1'b0}}, step_q};
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_TCALC: begin
        t_d = (t_wide > {{(AW + 1 - 32){1'b0}}, norm_q}) ? norm_q : t_wide[31:0];
        axis_d = 2'd0;
        if (norm_q == '0) begin
          for (int a = 0; a < 3; a++) off_d[a] = '0;
          st_d = S_PUT;
        end else begin
          st_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = {1'b0, 63'(mag_sel * mul_b)};
        st_d   = S_DIVI;
      end
      S_DIVI: begin
        drem_d = prod_q[62:31]; dsh_d = prod_q[30:0]; it_d = '0;
        st_d   = S_DIV;
      end
      S_DIV: begin
        drem_d = dv_ge ? 32'(dv_r2 - {1'b0, norm_q}) : dv_r2[31:0];
        dsh_d  = {dsh_q[29:0], 1'b0};
        quo_d  = {quo_q[29:0], dv_ge};
        it_d   = it_q + 5'd1;
        if (it_q == 5'd30) begin
          off_d[axis_q] = {quo_q[29:0], dv_ge};
          if (axis_q == 2'd2) st_d = S_PUT;
          else begin
            axis_d = axis_q + 2'd1;
            st_d   = S_MUL;
          end
        end
      end
      S_PUT: begin
        if (out_free) begin
          load  = 1'b1;
          acc_d = acc_q - {{(AW - 31){1'b0}}, step_q};
          k_d   = k_q + CW'(1);
          if (k_q == cnt_q - CW'(1)) st_d = last_q ? S_FINAL : S_IDLE;
          else                       st_d = S_TCALC;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          load      = 1'b1;
          acc_d     = '0;
          started_d = 1'b0;
          for (int a = 0; a < 3; a++) prev_d[a] = '0;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign ovld_d = load ? 1'b1 : (ovld_q && out_stall_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      step_q    <= plr_pkg::STEP_RESET;
      started_q <= 1'b0;
      acc_q     <= '0;
      ovld_q    <= 1'b0;
      cnt_q     <= '0;
      k_q       <= '0;
      for (int a = 0; a < 3; a++) prev_q[a] <= '0;
    end else begin
      st_q      <= st_d;
      started_q <= started_d;
      acc_q     <= acc_d;
      ovld_q    <= ovld_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      for (int a = 0; a < 3; a++) prev_q[a] <= prev_d[a];
      if (cfg_wr) step_q <= pwdata[30:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ph_q <= ph_d; prod_q <= prod_d; sum_q <= sum_d; rad_q <= rad_d;
    rem_q <= rem_d; root_q <= root_d; it_q <= it_d; norm_q <= norm_d;
    tmp_q <= tmp_d; trunc_q <= trunc_d; t_q <= t_d; axis_q <= axis_d;
    drem_q <= drem_d; dsh_q <= dsh_d; quo_q <= quo_d;
    for (int a = 0; a < 3; a++) begin
      s_q[a] <= s_d[a]; diff_q[a] <= diff_d[a]; off_q[a] <= off_d[a];
    end
    if (in_acc) begin
      dir_q[0] <= dir_x_i; dir_q[1] <= dir_y_i; dir_q[2] <= dir_z_i;
      last_q   <= last_point_i;
    end
    if (load) begin
      for (int a = 0; a < 3; a++) begin
        opos_q[a] <= lpos[a]; odir_q[a] <= ldir[a];
      end
      okind_q  <= lkind;
      otrunc_q <= (st_q == S_FIRST) ? 1'b0 : trunc_q;
      olast_q  <= llast;
    end
  end

  assign out_valid_o   = ovld_q;
  assign out_x_o       = opos_q[0];
  assign out_y_o       = opos_q[1];
  assign out_z_o       = opos_q[2];
  assign out_dir_x_o   = odir_q[0];
  assign out_dir_y_o   = odir_q[1];
  assign out_dir_z_o   = odir_q[2];
  assign point_kind_o  = okind_q;
  assign truncated_o   = otrunc_q;
  assign last_result_o = olast_q;

  // checks
  `ASSERT_IMPL(a_first_is_last, out_valid_o && point_kind_o == plr_pkg::KIND_FIRST,
    last_result_o && !truncated_o, "first point must be a lone untruncated beat")
  `ASSERT_IMPL(a_busy_started, st_q != S_IDLE && st_q != S_FIRST, started_q,
    "segment work without a started polyline")
  `ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(plr_pkg::MAX_EMIT), "emission count overflow")
  `ASSERT_IMPL(a_put_index, st_q == S_PUT, k_q < cnt_q, "emission index beyond count")
  `ASSERT_IMPL(a_hold_out, ovld_q && out_stall_i && !load, ##1 ovld_q,
    "pending result lost")

endmodule

// ----- bench/plr_checker.sv -----
// ----------------------------------------------------------------------------
// plr_checker
// Watches the point and result channels, predicts the resampled points and
// compares every result beat field by field.
// ----------------------------------------------------------------------------
module plr_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [30:0] pos_x_i,
  input  logic signed [30:0] pos_y_i,
  input  logic signed [30:0] pos_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic               last_point_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic signed [31:0] out_z_i,
  input  logic signed [31:0] out_dir_x_i,
  input  logic signed [31:0] out_dir_y_i,
  input  logic signed [31:0] out_dir_z_i,
  input  logic [1:0]         point_kind_i,
  input  logic               truncated_i,
  input  logic               last_result_i,
  // step register value, mirrored by the top on each write
  input  logic [30:0]        step_i,
  output int                 fail_cnt_o,
  output int                 pend_cnt_o,
  output int                 got_cnt_o
);

  typedef struct packed {
    logic [31:0] x, y, z, dx, dy, dz;
    logic [1:0]  kind;
    logic        trunc;
    logic        last;
  } point_t;

  point_t      pts_q[$];
  longint      px, py, pz;
  logic [63:0] arc_acc;
  bit          in_line;
  int          fail_cnt, got_cnt, pend_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pend_cnt_o = pend_cnt;
  assign got_cnt_o  = got_cnt;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // signed offset d*t/norm, truncated toward zero on the magnitude
  function automatic longint interp_off(longint d, logic [63:0] t, logic [63:0] norm);
    logic [63:0] q, m;
    if (norm == 0) return 0;
    m = (d < 0) ? -d : d;
    q = (m * t) / norm;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // predict all result beats of one accepted point
  task automatic predict_points(longint sx, longint sy, longint sz,
                                logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                                bit lst);
    point_t      buf_q[$];
    point_t      p;
    longint      dx, dy, dz;
    logic [63:0] ax, ay, az, norm, t, stp;
    int          lim;
    bit          trunc, due;
    stp = {33'd0, step_i};
    if (!in_line) begin
      if (lst) return;
      p = '{sx[31:0], sy[31:0], sz[31:0], ix, iy, iz, plr_pkg::KIND_FIRST, 1'b0, 1'b1};
      pts_q = {pts_q, p};
      px = sx; py = sy; pz = sz;
      arc_acc = 0;
      in_line = 1;
      return;
    end
    dx = sx - px; dy = sy - py; dz = sz - pz;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    az = (dz < 0) ? -dz : dz;
    norm = int_sqrt(ax * ax + ay * ay + az * az);
    arc_acc = arc_acc + norm;
    if (arc_acc > 64'hFF_FFFF_FFFF) arc_acc = 64'hFF_FFFF_FFFF;
    lim = lst ? int'(plr_pkg::MAX_EMIT) - 1 : int'(plr_pkg::MAX_EMIT);
    trunc = 0;
    forever begin
      due = lst ? (arc_acc >= stp) : (arc_acc > stp);
      if (!due) break;
      if (buf_q.size() >= lim) begin
        trunc = 1;
        break;
      end
      t = arc_acc - stp;
      if (t > norm) t = norm;
      p.x = 32'(sx - interp_off(dx, t, norm));
      p.y = 32'(sy - interp_off(dy, t, norm));
      p.z = 32'(sz - interp_off(dz, t, norm));
      p.dx = dx[31:0]; p.dy = dy[31:0]; p.dz = dz[31:0];
      p.kind = plr_pkg::KIND_INTERP;
      buf_q = {buf_q, p};
      arc_acc = arc_acc - stp;
    end
    if (lst) begin
      p = '{sx[31:0], sy[31:0], sz[31:0], ix, iy, iz, plr_pkg::KIND_FINAL, 1'b0, 1'b0};
      buf_q = {buf_q, p};
      px = 0; py = 0; pz = 0; arc_acc = 0; in_line = 0;
    end else begin
      px = sx; py = sy; pz = sz;
    end
    foreach (buf_q[k]) begin
      buf_q[k].trunc = trunc;
      buf_q[k].last  = (k == buf_q.size() - 1);
      pts_q = {pts_q, buf_q[k]};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e, a;
    if (!rst_ni) begin
      px = 0; py = 0; pz = 0; arc_acc = 0; in_line = 0;
      fail_cnt = 0; got_cnt = 0; pend_cnt = 0;
      pts_q.delete();
    end else begin
      // compare result beats against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        a = '{out_x_i, out_y_i, out_z_i, out_dir_x_i, out_dir_y_i, out_dir_z_i,
              point_kind_i, truncated_i, last_result_i};
        got_cnt++;
        if (pts_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, a);
          fail_cnt++;
        end else begin
          e = pts_q.pop_front();
          if (e !== a) begin
            $display("%0t: mismatch exp x=%h y=%h z=%h d=%h/%h/%h k=%0d t=%b l=%b",
                     $time, e.x, e.y, e.z, e.dx, e.dy, e.dz, e.kind, e.trunc, e.last);
            $display("%0t:          act x=%h y=%h z=%h d=%h/%h/%h k=%0d t=%b l=%b",
                     $time, a.x, a.y, a.z, a.dx, a.dy, a.dz, a.kind, a.trunc, a.last);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_points(longint'(pos_x_i), longint'(pos_y_i), longint'(pos_z_i),
                       dir_x_i, dir_y_i, dir_z_i, last_point_i);
      pend_cnt = pts_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives polylines and step settings into the resampler, with random gaps on
// both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WDOG_LIMIT = 200000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic signed [30:0] pos_x_i = 0, pos_y_i = 0, pos_z_i = 0;
  logic signed [31:0] dir_x_i = 0, dir_y_i = 0, dir_z_i = 0;
  logic               last_point_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic signed [31:0] out_dir_x_o, out_dir_y_o, out_dir_z_o;
  logic [1:0]         point_kind_o;
  logic               truncated_o, last_result_o;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [1:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;
  logic [30:0]        step_mirror = plr_pkg::STEP_RESET;
  int                 fail_cnt, pend_cnt, got_cnt;
  int                 idle_cycles = 0;
  int                 n_lines = 0, n_pts = 0, n_steps = 0;
  bit                 stall_on = 1;

  always #4 clk_i = ~clk_i;

  polyline_arclength_resampler DUT (.*);

  plr_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .pos_x_i, .pos_y_i, .pos_z_i, .dir_x_i, .dir_y_i, .dir_z_i, .last_point_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .out_x_i(out_x_o), .out_y_i(out_y_o), .out_z_i(out_z_o),
    .out_dir_x_i(out_dir_x_o), .out_dir_y_i(out_dir_y_o), .out_dir_z_i(out_dir_z_o),
    .point_kind_i(point_kind_o), .truncated_i(truncated_o),
    .last_result_i(last_result_o), .step_i(step_mirror),
    .fail_cnt_o(fail_cnt), .pend_cnt_o(pend_cnt), .got_cnt_o(got_cnt)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // output stall: random runs, switched off for some stretches
  always @(posedge clk_i) begin
    if (stall_on && $urandom_range(0, 3) == 0)
      out_stall_i <= ($urandom_range(0, 7) == 0) ? 1'b1 : ~out_stall_i;
    else if (!stall_on || $urandom_range(0, 1) == 0)
      out_stall_i <= 1'b0;
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired, %0d results pending", pend_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pend_cnt != 0) @(posedge clk_i);
    // a point may still be in flight without causing a result
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_step(logic [30:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= plr_pkg::ADDR_STEP;
    pwdata <= {1'b0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    step_mirror <= v;
    n_steps++;
  endtask

  task automatic send_point(logic signed [30:0] x, y, z, bit lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    pos_x_i <= x; pos_y_i <= y; pos_z_i <= z;
    dir_x_i <= $urandom; dir_y_i <= $urandom; dir_z_i <= $urandom;
    last_point_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_pts++;
    if (lst) n_lines++;
  endtask

  task automatic send_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // polyline with segment sizes in a chosen magnitude
  task automatic send_line(int len, int span);
    logic signed [30:0] x, y, z;
    x = 31'($urandom); y = 31'($urandom); z = 31'($urandom);
    x = x >>> 4; y = y >>> 4; z = z >>> 4;
    for (int i = 0; i < len; i++) begin
      send_point(x, y, z, i == len - 1);
      x = 31'(x + $signed($urandom_range(0, 2 * span)) - span);
      y = 31'(y + $signed($urandom_range(0, 2 * span)) - span);
      if ($urandom_range(0, 5) != 0)
        z = 31'(z + $signed($urandom_range(0, 2 * span)) - span);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: lone point, extremes of coordinates, zero segment, exact step
    send_point(31'sd5, 31'sd6, 31'sd7, 1);
    send_point(-31'sd1073741824, -31'sd1073741824, -31'sd1073741824, 0);
    send_point(31'sd1073741823, 31'sd1073741823, 31'sd1073741823, 1);
    send_point(31'sd0, 31'sd0, 31'sd0, 0);
    send_point(31'sd0, 31'sd0, 31'sd0, 0);
    send_point(31'sd65536, 31'sd0, 31'sd0, 0);
    send_point(31'sd131072, 31'sd0, 31'sd0, 1);
    send_point(31'sd0, 31'sd0, 31'sd0, 0);
    send_point(31'sd0, -31'sd196608, 31'sd0, 1);
    send_idle();
    wait_drained();

    // smallest step: every segment truncates
    write_step(31'd1);
    send_point(31'sd100, 31'sd0, 31'sd0, 0);
    send_point(31'sd300, -31'sd5, 31'sd9, 0);
    send_point(31'sd0, 31'sd0, 31'sd0, 1);
    send_idle();
    wait_drained();

    // largest step: long lines barely emit
    write_step(31'h7FFF_FFFF);
    send_point(-31'sd1073741824, 31'sd1073741823, 31'sd0, 0);
    send_point(31'sd1073741823, -31'sd1073741824, 31'sd1073741823, 0);
    send_point(-31'sd1073741824, 31'sd1073741823, -31'sd1073741824, 1);
    send_idle();
    wait_drained();

    // random phases at several step sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_step(31'd65536);
        1: write_step(31'd4096);
        2: write_step(31'($urandom_range(1, 2000000)));
        3: write_step(31'd300000);
        4: write_step(31'($urandom));
        default: write_step(31'd20000);
      endcase
      stall_on = (ph != 3);
      for (int l = 0; l < 4; l++) begin
        if ($urandom_range(0, 9) == 0)
          send_point(31'($urandom), 31'($urandom), 31'($urandom),
                     1'($urandom_range(0, 1)));
        else
          send_line($urandom_range(2, 5),
                    ($urandom_range(0, 9) == 0) ? 1 << 28 : $urandom_range(1, 400000));
      end
      // close any open polyline before reconfiguring
      send_point(31'sd0, 31'sd0, 31'sd0, 1);
      send_idle();
      wait_drained();
    end

    $display("covered %0d points in %0d closed polylines, %0d step settings, %0d results",
             n_pts, n_lines, n_steps, got_cnt);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- polyline_arclength_resampler.f -----
+incdir+design
design/plr_pkg.sv
design/polyline_arclength_resampler.sv
bench/plr_checker.sv
bench/tb_top.sv
